// ----- design/sorted_region_table_macros.svh -----
// assertion helpers for the region table
`ifndef SORTED_REGION_TABLE_MACROS_SVH
`define SORTED_REGION_TABLE_MACROS_SVH

// a condition that must hold at every edge outside reset
`define SRT_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// an implication checked on the next edge
`define SRT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/srt_pkg.sv -----
`default_nettype none
package srt_pkg;
  localparam int MaxRegions = 64;
  localparam int IdxBits = $clog2(MaxRegions);
  localparam int CntBits = $clog2(MaxRegions + 1);
  localparam int AddrBits = 48;
  localparam int EntryBits = 2 * AddrBits + 64;
  localparam logic [AddrBits-1:0] PageLow = AddrBits'(4095);
  localparam logic [AddrBits-1:0] GapBaseReset = AddrBits'(64'h0400_0000);
  localparam logic [AddrBits-1:0] GapLimitReset = AddrBits'(64'h1000_0000);

  localparam logic [2:0] KindInsert = 3'd0;
  localparam logic [2:0] KindLookup = 3'd1;
  localparam logic [2:0] KindRemove = 3'd2;
  localparam logic [2:0] KindGap = 3'd3;
  localparam logic [2:0] KindClear = 3'd4;

  localparam logic [1:0] StatusOk = 2'd0;
  localparam logic [1:0] StatusMiss = 2'd1;
  localparam logic [1:0] StatusFull = 2'd2;

  localparam logic RegGapBase = 1'b0;
  localparam logic RegGapLimit = 1'b1;

  typedef struct packed {
    logic [2:0] kind;
    logic [AddrBits-1:0] addr;
    logic [AddrBits-1:0] end_or_length;
    logic [31:0] prot_bits;
    logic [31:0] flag_bits;
  } cmd_t;

  typedef struct packed {
    logic [1:0] status;
    logic [AddrBits-1:0] hit_start;
    logic [AddrBits-1:0] hit_end;
    logic [31:0] hit_prot;
    logic [31:0] hit_flags;
    logic [AddrBits-1:0] gap_addr;
  } rsp_t;

  typedef struct packed {
    logic [AddrBits-1:0] rstart;
    logic [AddrBits-1:0] rend;
    logic [31:0] prot;
    logic [31:0] flags;
  } entry_t;
endpackage
`default_nettype wire

// ----- design/srt_ram.sv -----
`default_nettype none
module srt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input wire logic clk,
  input wire logic we,
  input wire logic [$clog2(Depth)-1:0] waddr,
  input wire logic [Width-1:0] wdata,
  input wire logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0] rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- design/sorted_region_table.sv -----
// Region table: up to 64 address regions kept sorted by start address.
// Commands enter on start/cmd while busy is low; busy rises on the next
// cycle and stays high until the single result is shown on rsp for one
// cycle with done high. The receiver cannot stall; a result is never held.
// The entries sit in one single-port-write RAM with a registered read, and
// one sequencer walks it one entry per step, each step a read state and a
// compare/write state through one shared comparator path.
// A lookup, a gap search or a remove may walk the whole table; an insert
// walks to its slot and then moves every later entry up one place, or
// writes its entry directly when it lands at the end; a matching remove
// moves later entries down. Clear, an unknown kind, an insert into a full
// table and a gap length that rounds past the address range end after a
// single read and evaluation, without walking the table.
// A new command is taken in the cycle after done.
// The gap_base and gap_limit registers sit on the APB port at byte
// addresses 0 and 8; write them only while busy is low.
// Reset empties the table (count zero) and loads the register defaults;
// the RAM contents are not cleared since only counted entries are read.
`default_nettype none
`include "sorted_region_table_macros.svh"
module sorted_region_table (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  output logic busy,
  input wire srt_pkg::cmd_t cmd,
  output logic done,
  output srt_pkg::rsp_t rsp,
  input wire logic psel,
  input wire logic penable,
  input wire logic pwrite,
  input wire logic [3:0] paddr,
  input wire logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic pready
);
  localparam int AB = srt_pkg::AddrBits;
  localparam int IB = srt_pkg::IdxBits;
  localparam int CB = srt_pkg::CntBits;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_READ  = 7'b0000010,
    S_EVAL  = 7'b0000100,
    S_SHRD  = 7'b0001000,
    S_SHWR  = 7'b0010000,
    S_FINAL = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state, state_next;
  srt_pkg::cmd_t op;
  logic [AB-1:0] gap_base, gap_limit, cur, glen;
  logic [CB-1:0] count, idx;
  logic [CB-1:0] found_idx;
  logic [1:0] status;
  logic [1:0] status_fwd;
  srt_pkg::rsp_t rsp_q;

  logic ram_we;
  logic [IB-1:0] ram_waddr, ram_raddr;
  srt_pkg::entry_t ram_wdata, ram_rdata;

  srt_ram #(.Width(srt_pkg::EntryBits), .Depth(srt_pkg::MaxRegions)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  assign pready = 1'b1;
  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);
  assign rsp = rsp_q;

  always_comb begin
    prdata = '0;
    if (paddr[3] == srt_pkg::RegGapLimit) begin
      prdata[AB-1:0] = gap_limit;
    end else begin
      prdata[AB-1:0] = gap_base;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gap_base <= srt_pkg::GapBaseReset;
      gap_limit <= srt_pkg::GapLimitReset;
    end else if (psel && penable && pwrite) begin
      if (paddr[3] == srt_pkg::RegGapLimit) begin
        gap_limit <= pwdata[AB-1:0];
      end else begin
        gap_base <= pwdata[AB-1:0];
      end
    end
  end

  // shared datapath terms
  logic [AB:0] rem_sum, len_round;
  logic [AB-1:0] rem_end, clamp;
  logic fits_entry, fits_limit, hit, match, start_below;
  assign rem_sum = {1'b0, op.addr} + {1'b0, op.end_or_length};
  assign rem_end = rem_sum[AB-1:0];
  assign len_round = {1'b0, cmd.end_or_length} + {1'b0, srt_pkg::PageLow};
  assign fits_entry = (cur <= ram_rdata.rstart) && (glen <= ram_rdata.rstart - cur);
  assign fits_limit = (cur <= gap_limit) && (glen <= gap_limit - cur);
  assign hit = (op.addr >= ram_rdata.rstart) && (op.addr < ram_rdata.rend);
  // an end past the address range matches nothing
  assign match = !rem_sum[AB] && (ram_rdata.rstart == op.addr) && (ram_rdata.rend == rem_end);
  assign start_below = (ram_rdata.rstart < op.addr);
  assign clamp = (ram_rdata.rend > gap_base) ? ram_rdata.rend : gap_base;

  logic [CB-1:0] idx_m1;
  assign idx_m1 = idx - CB'(1);

  always_comb begin
    state_next = state;
    ram_we = 1'b0;
    ram_waddr = idx[IB-1:0];
    ram_wdata = ram_rdata;
    ram_raddr = idx[IB-1:0];
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        state_next = S_EVAL;
      end
      S_EVAL: begin
        state_next = S_READ;
        case (op.kind)
          srt_pkg::KindInsert: begin
            if (idx == count || !start_below) begin
              state_next = (idx == count) ? S_FINAL : S_SHRD;
            end
          end
          srt_pkg::KindLookup: begin
            if (idx == count || hit) begin
              state_next = S_DONE;
            end
          end
          srt_pkg::KindRemove: begin
            if (idx == count) begin
              state_next = S_DONE;
            end else if (match) begin
              state_next = S_SHRD;
            end
          end
          srt_pkg::KindGap: begin
            if (idx == count || (fits_entry && cur < gap_limit) || clamp >= gap_limit) begin
              state_next = S_DONE;
            end
          end
          default: state_next = S_DONE;
        endcase
        if (idx == count && op.kind == srt_pkg::KindInsert) begin
          state_next = S_FINAL;
        end
      end
      S_SHRD: begin
        // insert reads idx-1 moving upward; remove reads idx+1
        if (op.kind == srt_pkg::KindInsert) begin
          ram_raddr = idx_m1[IB-1:0];
        end else begin
          ram_raddr = IB'(idx + CB'(1));
        end
        state_next = S_SHWR;
      end
      S_SHWR: begin
        ram_we = 1'b1;
        state_next = S_SHRD;
        if (op.kind == srt_pkg::KindInsert) begin
          if (idx == found_idx) begin
            ram_wdata = '{op.addr, op.end_or_length, op.prot_bits, op.flag_bits};
            state_next = S_DONE;
          end
        end else if (idx + CB'(2) >= count) begin
          state_next = S_DONE;
          ram_we = (idx + CB'(1) < count);
        end
      end
      S_FINAL: begin
        ram_we = 1'b1;
        ram_wdata = '{op.addr, op.end_or_length, op.prot_bits, op.flag_bits};
        state_next = S_DONE;
      end
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (start) begin
            op <= cmd;
            idx <= '0;
            cur <= gap_base;
            glen <= len_round[AB-1:0] & ~srt_pkg::PageLow;
            status <= srt_pkg::StatusMiss;
            rsp_q <= '0;
            if (cmd.kind == srt_pkg::KindClear) begin
              count <= '0;
              status <= srt_pkg::StatusOk;
            end
            if (cmd.kind == srt_pkg::KindInsert && count == CB'(srt_pkg::MaxRegions)) begin
              status <= srt_pkg::StatusFull;
              op.kind <= srt_pkg::KindClear;
            end
            // a length that rounds past the address range has no gap
            if (cmd.kind == srt_pkg::KindGap && len_round[AB]) begin
              op.kind <= srt_pkg::KindClear;
            end
            if (cmd.kind > srt_pkg::KindGap) begin
              op.kind <= srt_pkg::KindClear;
            end
          end
        end
        S_EVAL: begin
          idx <= idx + CB'(1);
          case (op.kind)
            srt_pkg::KindInsert: begin
              if (idx == count || !start_below) begin
                found_idx <= idx;
                idx <= count;
                status <= srt_pkg::StatusOk;
              end
              if (idx == count) begin
                idx <= idx;
                count <= count + CB'(1);
              end
            end
            srt_pkg::KindLookup: begin
              if (idx != count && hit) begin
                status <= srt_pkg::StatusOk;
                rsp_q.hit_start <= ram_rdata.rstart;
                rsp_q.hit_end <= ram_rdata.rend;
                rsp_q.hit_prot <= ram_rdata.prot;
                rsp_q.hit_flags <= ram_rdata.flags;
              end
            end
            srt_pkg::KindRemove: begin
              if (idx != count && match) begin
                idx <= idx;
              end
            end
            srt_pkg::KindGap: begin
              if (idx == count) begin
                if (fits_limit) begin
                  status <= srt_pkg::StatusOk;
                  rsp_q.gap_addr <= cur;
                end
              end else if (fits_entry && cur < gap_limit) begin
                status <= srt_pkg::StatusOk;
                rsp_q.gap_addr <= cur;
              end else begin
                cur <= clamp;
              end
            end
            default: ;
          endcase
        end
        S_SHWR: begin
          if (op.kind == srt_pkg::KindInsert) begin
            if (idx == found_idx) begin
              count <= count + CB'(1);
            end else begin
              idx <= idx_m1;
            end
          end else if (idx + CB'(2) >= count) begin
            count <= count - CB'(1);
            status <= srt_pkg::StatusOk;
          end else begin
            idx <= idx + CB'(1);
          end
        end
        S_DONE: rsp_q.status <= status;
        default: ;
      endcase
      if (state_next == S_DONE) begin
        rsp_q.status <= status_fwd;
      end
    end
  end

  // status as it will be after this edge's updates, for an edge that enters S_DONE
  always_comb begin
    status_fwd = status;
    if (state == S_EVAL) begin
      if (op.kind == srt_pkg::KindLookup && idx != count && hit) begin
        status_fwd = srt_pkg::StatusOk;
      end
      if (op.kind == srt_pkg::KindGap) begin
        if ((idx == count && fits_limit) || (idx != count && fits_entry && cur < gap_limit)) begin
          status_fwd = srt_pkg::StatusOk;
        end
      end
      if (op.kind == srt_pkg::KindInsert && idx == count) begin
        status_fwd = srt_pkg::StatusOk;
      end
    end
    if (state == S_SHWR) begin
      status_fwd = srt_pkg::StatusOk;
    end
  end

  `SRT_ASSERT_ALWAYS(a_count_max, count <= CB'(srt_pkg::MaxRegions), "count overflow")
  `SRT_ASSERT_NEXT(a_done_one, done, !done, "done held two cycles")
  `SRT_ASSERT_NEXT(a_start_busy, start && !busy, busy, "busy did not rise")
  `SRT_ASSERT_ALWAYS(a_done_busy, !done || busy, "done while idle")
endmodule
`default_nettype wire

// ----- test/sorted_region_table_tb.sv -----
`default_nettype none
module sorted_region_table_tb;
  import srt_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  cmd_t cmd = '0;
  logic done;
  rsp_t rsp;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;

  sorted_region_table dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd), .done(done),
    .rsp(rsp), .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #1 clk = ~clk;

  // local copy of the table
  entry_t tbl [MaxRegions];
  int unsigned tbl_count;
  logic [AddrBits-1:0] base_q = GapBaseReset;
  logic [AddrBits-1:0] limit_q = GapLimitReset;

  rsp_t pending_rsp[$];
  int unsigned mismatches = 0;
  bit quiet = 1'b0;

  localparam logic [AddrBits-1:0] AddrMax = {AddrBits{1'b1}};

  function automatic bit fits_below(logic [AddrBits-1:0] lo, logic [AddrBits-1:0] len,
                                    logic [AddrBits-1:0] hi);
    if (lo > hi) return 1'b0;
    return len <= hi - lo;
  endfunction

  function automatic bit search_gap(logic [AddrBits-1:0] len_in,
                                    output logic [AddrBits-1:0] where);
    logic [AddrBits-1:0] cur;
    logic [AddrBits-1:0] len;
    where = '0;
    cur = base_q;
    if (len_in > AddrMax - PageLow) return 1'b0;
    len = (len_in + PageLow) & ~PageLow;
    for (int i = 0; i < tbl_count; i++) begin
      if (fits_below(cur, len, tbl[i].rstart) && cur < limit_q) begin
        where = cur;
        return 1'b1;
      end
      cur = (tbl[i].rend > base_q) ? tbl[i].rend : base_q;
      if (cur >= limit_q) return 1'b0;
    end
    if (fits_below(cur, len, limit_q)) begin
      where = cur;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic rsp_t apply_command(cmd_t c);
    rsp_t r;
    int i;
    logic [AddrBits-1:0] e;
    logic [AddrBits-1:0] g;
    r = '0;
    r.status = StatusMiss;
    case (c.kind)
      KindInsert: begin
        if (tbl_count >= MaxRegions) begin
          r.status = StatusFull;
        end else begin
          i = 0;
          while (i < tbl_count && tbl[i].rstart < c.addr) i++;
          for (int j = tbl_count; j > i; j--) tbl[j] = tbl[j-1];
          tbl[i] = '{c.addr, c.end_or_length, c.prot_bits, c.flag_bits};
          tbl_count++;
          r.status = StatusOk;
        end
      end
      KindLookup: begin
        for (i = 0; i < tbl_count; i++) begin
          if (c.addr >= tbl[i].rstart && c.addr < tbl[i].rend) begin
            r.status = StatusOk;
            r.hit_start = tbl[i].rstart;
            r.hit_end = tbl[i].rend;
            r.hit_prot = tbl[i].prot;
            r.hit_flags = tbl[i].flags;
            break;
          end
        end
      end
      KindRemove: begin
        if (c.end_or_length <= AddrMax - c.addr) begin
          e = c.addr + c.end_or_length;
          for (i = 0; i < tbl_count; i++) begin
            if (tbl[i].rstart == c.addr && tbl[i].rend == e) begin
              for (int j = i; j + 1 < tbl_count; j++) tbl[j] = tbl[j+1];
              tbl_count--;
              r.status = StatusOk;
              break;
            end
          end
        end
      end
      KindGap: begin
        if (search_gap(c.end_or_length, g)) begin
          r.status = StatusOk;
          r.gap_addr = g;
        end
      end
      KindClear: begin
        tbl_count = 0;
        r.status = StatusOk;
      end
      default: ;
    endcase
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", rsp);
      end else begin
        rsp_t want;
        want = pending_rsp.pop_front();
        if (rsp !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, rsp);
        end
      end
    end
  end

  task automatic idle_gap();
    if (!quiet && $urandom_range(99) < 15)
      repeat ($urandom_range(1, 6)) @(posedge clk);
  endtask

  task automatic send_cmd(cmd_t c);
    idle_gap();
    start <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (busy);
    pending_rsp.push_back(apply_command(c));
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic reg_sel, logic [AddrBits-1:0] value);
    drain();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= (reg_sel == RegGapLimit) ? 4'd8 : 4'd0;
    pwdata <= 64'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (reg_sel == RegGapLimit) limit_q = value;
    else base_q = value;
  endtask

  function automatic logic [AddrBits-1:0] rand_addr();
    return {16'($urandom), 32'($urandom)};
  endfunction

  function automatic cmd_t make_cmd(logic [2:0] k, logic [AddrBits-1:0] a,
                                    logic [AddrBits-1:0] b);
    cmd_t c;
    c.kind = k;
    c.addr = a;
    c.end_or_length = b;
    c.prot_bits = $urandom;
    c.flag_bits = $urandom;
    return c;
  endfunction

  task automatic test_directed();
    cmd_t c;
    send_cmd(make_cmd(KindGap, '0, 48'h1));
    send_cmd(make_cmd(KindInsert, 48'h0500_0000, 48'h0600_0000));
    c = make_cmd(KindInsert, 48'h0500_0000, 48'h0500_8000);
    c.prot_bits = '1;
    c.flag_bits = '0;
    send_cmd(c);
    c = make_cmd(KindInsert, AddrMax, '0);
    c.prot_bits = '0;
    c.flag_bits = '1;
    send_cmd(c);
    send_cmd(make_cmd(KindInsert, 48'h10, 48'h8));
    send_cmd(make_cmd(KindLookup, 48'h0500_1000, '0));
    send_cmd(make_cmd(KindLookup, 48'h0580_0000, '0));
    send_cmd(make_cmd(KindLookup, 48'hC, '0));
    send_cmd(make_cmd(KindLookup, AddrMax, '0));
    send_cmd(make_cmd(KindGap, '0, 48'h0100_0000));
    send_cmd(make_cmd(KindGap, '0, '0));
    send_cmd(make_cmd(KindGap, '0, AddrMax));
    send_cmd(make_cmd(KindGap, '0, AddrMax - PageLow));
    send_cmd(make_cmd(KindRemove, AddrMax, 48'h1));
    send_cmd(make_cmd(KindRemove, 48'h0500_0000, 48'h8000));
    send_cmd(make_cmd(KindRemove, 48'h0500_0000, 48'h8000));
    send_cmd(make_cmd(3'd5, AddrMax, AddrMax));
    send_cmd(make_cmd(3'd7, '0, '0));
    send_cmd(make_cmd(KindClear, '0, '0));
    send_cmd(make_cmd(KindLookup, 48'h0500_1000, '0));
  endtask

  task automatic test_full_table();
    for (int i = 0; i < MaxRegions + 2; i++)
      send_cmd(make_cmd(KindInsert, rand_addr(), rand_addr()));
    send_cmd(make_cmd(KindLookup, rand_addr(), '0));
    // hold off until the table has answered everything
    drain();
    send_cmd(make_cmd(KindClear, '0, '0));
  endtask

  task automatic test_gap_base_zero();
    write_reg(RegGapBase, '0);
    write_reg(RegGapLimit, AddrMax);
    send_cmd(make_cmd(KindGap, '0, 48'h1000));
    send_cmd(make_cmd(KindInsert, '0, 48'h3000));
    send_cmd(make_cmd(KindGap, '0, 48'h1000));
    send_cmd(make_cmd(KindInsert, 48'h4000, 48'h5000));
    send_cmd(make_cmd(KindGap, '0, 48'h1001));
    send_cmd(make_cmd(KindClear, '0, '0));
  endtask

  // mostly page-sized regions in a narrow window so gaps and hits happen
  task automatic random_phase(int n, logic [AddrBits-1:0] lo, logic [AddrBits-1:0] span);
    cmd_t c;
    logic [AddrBits-1:0] a;
    int sel;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      a = lo + ((AddrBits'($urandom_range(0, 511)) * span) >> 9);
      a &= ~PageLow;
      if (sel < 35) begin
        if (tbl_count > 40 && $urandom_range(3) != 0) c = make_cmd(KindClear, '0, '0);
        else c = make_cmd(KindInsert, a, a + (AddrBits'($urandom_range(1, 64)) << 12));
      end else if (sel < 55) begin
        c = make_cmd(KindLookup, a + AddrBits'($urandom_range(0, 8191)), '0);
      end else if (sel < 70) begin
        if (tbl_count != 0 && $urandom_range(3) != 0) begin
          int k = $urandom_range(0, tbl_count - 1);
          c = make_cmd(KindRemove, tbl[k].rstart, tbl[k].rend - tbl[k].rstart);
        end else begin
          c = make_cmd(KindRemove, a, AddrBits'($urandom_range(0, 65536)));
        end
      end else if (sel < 88) begin
        c = make_cmd(KindGap, '0, AddrBits'($urandom_range(0, 1 << 18)));
      end else if (sel < 93) begin
        c = make_cmd(3'($urandom_range(0, 7)), rand_addr(), rand_addr());
      end else if (sel < 95) begin
        c = make_cmd(KindClear, '0, '0);
      end else begin
        c = make_cmd(3'($urandom_range(0, 3)), rand_addr(), rand_addr());
      end
      send_cmd(c);
    end
  endtask

  task automatic test_random();
    write_reg(RegGapBase, 48'h0400_0000);
    write_reg(RegGapLimit, 48'h0440_0000);
    random_phase(250, 48'h03F0_0000, 48'h0060_0000);
    quiet = 1'b1;
    random_phase(100, 48'h03F0_0000, 48'h0060_0000);
    quiet = 1'b0;
    write_reg(RegGapBase, AddrMax - 48'h0010_0000);
    write_reg(RegGapLimit, AddrMax);
    random_phase(200, AddrMax - 48'h0020_0000, 48'h0020_0000);
    write_reg(RegGapBase, 48'h0010_0000);
    write_reg(RegGapLimit, 48'h0008_0000);
    random_phase(150, '0, 48'h0020_0000);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    tbl_count = 0;
    test_directed();
    test_full_table();
    test_gap_base_zero();
    test_random();
    drain();
    repeat (200) @(posedge clk);
    if (mismatches == 0 && pending_rsp.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end
endmodule
`default_nettype wire
